### sv/nab_pkg.sv
// Shared types, constants and helpers for the 3x3 neighbour blur.
package nab_pkg;

  // Channel and pixel layout.
  localparam int CHAN_BITS  = 8;
  localparam int PIXEL_BITS = 3 * CHAN_BITS;

  typedef struct packed {
    logic [CHAN_BITS-1:0] red;
    logic [CHAN_BITS-1:0] green;
    logic [CHAN_BITS-1:0] blue;
  } pixel_t;

  typedef struct packed {
    pixel_t pix;
    logic   frame_end;
  } result_t;

  // Configuration register map.
  localparam int REG_INDEX_BITS  = 1;
  localparam int CFG_DATA_BITS   = 13;
  localparam int WIDTH_REG_BITS  = 11;
  localparam int HEIGHT_REG_BITS = 13;

  localparam logic [REG_INDEX_BITS-1:0] REG_FRAME_WIDTH  = 1'd0;
  localparam logic [REG_INDEX_BITS-1:0] REG_FRAME_HEIGHT = 1'd1;

  localparam int WIDTH_RESET  = 640;
  localparam int HEIGHT_RESET = 480;

  // Item codes on the operation field.
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  // Output queue.
  localparam int FIFO_DEPTH = 3;
  localparam int QPTR_BITS  = 2;
  localparam int QCNT_BITS  = 2;

  // Sum of eight channel values, each divided by 8 with truncation first.
  function automatic logic [CHAN_BITS-1:0] nb_sum(
    input logic [CHAN_BITS-1:0] a, input logic [CHAN_BITS-1:0] b,
    input logic [CHAN_BITS-1:0] c, input logic [CHAN_BITS-1:0] d,
    input logic [CHAN_BITS-1:0] e, input logic [CHAN_BITS-1:0] f,
    input logic [CHAN_BITS-1:0] g, input logic [CHAN_BITS-1:0] h);
    logic [CHAN_BITS-1:0] s;
    s = {3'b000, a[CHAN_BITS-1:3]} + {3'b000, b[CHAN_BITS-1:3]}
      + {3'b000, c[CHAN_BITS-1:3]} + {3'b000, d[CHAN_BITS-1:3]}
      + {3'b000, e[CHAN_BITS-1:3]} + {3'b000, f[CHAN_BITS-1:3]}
      + {3'b000, g[CHAN_BITS-1:3]} + {3'b000, h[CHAN_BITS-1:3]};
    return s;
  endfunction

endpackage

### sv/nab_ram.sv
// Generic single-write, single-read RAM with registered, read-first output.
module nab_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // A read at the address being written returns the old contents.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### sv/neighbour_average_blur_3x3.sv
// Top level of the streaming 3x3 neighbour blur for RGB raster frames.
//
// Pixels enter in raster order and leave in raster order, one pixel per clock
// when the consumer keeps up. Border pixels pass through unchanged; every
// interior pixel becomes, per channel, the sum of its eight neighbours each
// divided by 8 first. A result appears for the item frame_width+1 places
// later in the input stream, so after the frame's last pixel the producer
// sends frame_width+1 flush items; the last result carries frame_end. Each
// item passes through the accept stage (counters and line-store read) and
// the window stage (window shift, neighbour sum, line-store write), then
// waits in a three-entry output queue. The sustained rate of one item per
// cycle, while the output queue leaves the input open, is set by the line
// stores, each read once and written once per cycle. Writing a configuration
// register restarts the frame. The line stores need no clearing after reset.
module neighbour_average_blur_3x3 #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               write_enable,
  input  logic [nab_pkg::REG_INDEX_BITS-1:0] write_index,
  input  logic [nab_pkg::CFG_DATA_BITS-1:0]  write_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               operation,
  input  logic [nab_pkg::CHAN_BITS-1:0]      red_in,
  input  logic [nab_pkg::CHAN_BITS-1:0]      green_in,
  input  logic [nab_pkg::CHAN_BITS-1:0]      blue_in,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [nab_pkg::CHAN_BITS-1:0]      red_out,
  output logic [nab_pkg::CHAN_BITS-1:0]      green_out,
  output logic [nab_pkg::CHAN_BITS-1:0]      blue_out,
  output logic                               frame_end
);
  import nab_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int CW = AW + 1;
  localparam int HB = $clog2(MAX_HEIGHT);
  localparam int RW = HB + 1;
  localparam int WIDTH_INIT  = (WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET;
  localparam int HEIGHT_INIT = (HEIGHT_RESET > MAX_HEIGHT) ? MAX_HEIGHT : HEIGHT_RESET;

  // Configuration and position state.
  logic [CW-1:0] frame_width;
  logic [RW-1:0] frame_height;
  logic [AW-1:0] in_column;
  logic [RW-1:0] in_row;
  logic [AW-1:0] out_column;
  logic [HB-1:0] out_row;
  logic [CW-1:0] pending_count;

  // Window stage registers.
  logic          b_valid;
  logic          b_emit;
  logic          b_border;
  logic          b_last;
  logic [AW-1:0] b_col;
  pixel_t        b_cur;
  logic          b_fwd;
  pixel_t        b_fwd_up;
  pixel_t        b_fwd_mid;

  // Window columns: win_c1 is the oldest column, win_c2 the middle one.
  pixel_t win_c1 [3];
  pixel_t win_c2 [3];

  // Output queue.
  result_t              q [FIFO_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QCNT_BITS-1:0] q_count;

  logic          draining;
  logic          in_fire;
  logic          take;
  logic          cfg_hit;
  pixel_t        cur_pix;
  logic [CW-1:0] width_m1;
  logic [RW-1:0] height_m1;
  logic [CW-1:0] col_ext;
  logic [RW-1:0] row_ext;
  logic          emit;
  logic          border;
  logic          last;
  logic [CW-1:0] col_inc;
  logic [31:0]   wv;
  logic [31:0]   hv;
  logic [CW-1:0] width_clamped;
  logic [RW-1:0] height_clamped;
  pixel_t        up_rd;
  pixel_t        mid_rd;
  pixel_t        up_eff;
  pixel_t        mid_eff;
  result_t       res;
  logic          push;
  logic          pop;

  // Register writes clamp their value into the supported range.
  always_comb begin
    wv = 32'(write_data[WIDTH_REG_BITS-1:0]);
    hv = 32'(write_data[HEIGHT_REG_BITS-1:0]);
    if (wv == 32'd0) begin
      width_clamped = CW'(1);
    end else if (wv > 32'(MAX_WIDTH)) begin
      width_clamped = CW'(MAX_WIDTH);
    end else begin
      width_clamped = wv[CW-1:0];
    end
    if (hv == 32'd0) begin
      height_clamped = RW'(1);
    end else if (hv > 32'(MAX_HEIGHT)) begin
      height_clamped = RW'(MAX_HEIGHT);
    end else begin
      height_clamped = hv[RW-1:0];
    end
  end

  assign cfg_hit = write_enable &&
                   (write_index == REG_FRAME_WIDTH || write_index == REG_FRAME_HEIGHT);

  // Accept stage decisions, the position ones from the registered position state.
  assign draining  = (in_row >= frame_height);
  assign in_fire   = in_valid && in_ready;
  assign take      = in_fire && !(operation == OP_FLUSH && !draining);
  assign cur_pix   = draining ? pixel_t'('0) : {red_in, green_in, blue_in};
  assign width_m1  = frame_width - 1'b1;
  assign height_m1 = frame_height - 1'b1;
  assign col_ext   = {1'b0, out_column};
  assign row_ext   = {1'b0, out_row};
  assign emit      = (pending_count > frame_width);
  assign border    = (out_column == '0) || (out_row == '0) ||
                     (col_ext == width_m1) || (row_ext == height_m1);
  assign last      = (row_ext >= height_m1) && (col_ext >= width_m1);
  assign col_inc   = {1'b0, in_column} + 1'b1;

  // Configuration, input position and output position counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width   <= CW'(WIDTH_INIT);
      frame_height  <= RW'(HEIGHT_INIT);
      in_column     <= '0;
      in_row        <= '0;
      out_column    <= '0;
      out_row       <= '0;
      pending_count <= '0;
    end else if (cfg_hit) begin
      case (write_index)
        REG_FRAME_WIDTH: begin
          frame_width <= width_clamped;
        end
        REG_FRAME_HEIGHT: begin
          frame_height <= height_clamped;
        end
        default: begin
        end
      endcase
      in_column     <= '0;
      in_row        <= '0;
      out_column    <= '0;
      out_row       <= '0;
      pending_count <= '0;
    end else if (take) begin
      if (emit && last) begin
        in_column     <= '0;
        in_row        <= '0;
        out_column    <= '0;
        out_row       <= '0;
        pending_count <= '0;
      end else begin
        if (col_inc >= frame_width) begin
          in_column <= '0;
          in_row    <= in_row + 1'b1;
        end else begin
          in_column <= col_inc[AW-1:0];
        end
        if (emit) begin
          if (col_ext + 1'b1 >= frame_width) begin
            out_column <= '0;
            out_row    <= out_row + 1'b1;
          end else begin
            out_column <= out_column + 1'b1;
          end
        end else begin
          pending_count <= pending_count + 1'b1;
        end
      end
    end
  end

  // Hand the taken item to the window stage; flag a same-column hazard.
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      b_emit    <= emit;
      b_border  <= border;
      b_last    <= last;
      b_col     <= in_column;
      b_cur     <= cur_pix;
      b_fwd     <= b_valid && (b_col == in_column);
      b_fwd_up  <= mid_eff;
      b_fwd_mid <= b_cur;
    end
  end

  // Line stores: upper holds two rows back, middle one row back.
  nab_ram #(
    .WIDTH (PIXEL_BITS),
    .DEPTH (MAX_WIDTH)
  ) u_upper_row (
    .clk   (clk),
    .we    (b_valid),
    .waddr (b_col),
    .wdata (mid_eff),
    .re    (take),
    .raddr (in_column),
    .rdata (up_rd)
  );

  nab_ram #(
    .WIDTH (PIXEL_BITS),
    .DEPTH (MAX_WIDTH)
  ) u_middle_row (
    .clk   (clk),
    .we    (b_valid),
    .waddr (b_col),
    .wdata (b_cur),
    .re    (take),
    .raddr (in_column),
    .rdata (mid_rd)
  );

  // When the previous item wrote the same column as this read, its data wins.
  assign up_eff  = b_fwd ? b_fwd_up : up_rd;
  assign mid_eff = b_fwd ? b_fwd_mid : mid_rd;

  // Window shift.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < 3; r++) begin
        win_c1[r] <= '0;
        win_c2[r] <= '0;
      end
    end else if (b_valid) begin
      for (int r = 0; r < 3; r++) begin
        win_c1[r] <= win_c2[r];
      end
      win_c2[0] <= up_eff;
      win_c2[1] <= mid_eff;
      win_c2[2] <= b_cur;
    end
  end

  // Result: centre pass-through on the border, neighbour sum inside.
  always_comb begin
    res.frame_end = b_last;
    if (b_border) begin
      res.pix = win_c2[1];
    end else begin
      res.pix.red   = nb_sum(win_c1[0].red, win_c2[0].red, up_eff.red,
                             win_c1[1].red, mid_eff.red,
                             win_c1[2].red, win_c2[2].red, b_cur.red);
      res.pix.green = nb_sum(win_c1[0].green, win_c2[0].green, up_eff.green,
                             win_c1[1].green, mid_eff.green,
                             win_c1[2].green, win_c2[2].green, b_cur.green);
      res.pix.blue  = nb_sum(win_c1[0].blue, win_c2[0].blue, up_eff.blue,
                             win_c1[1].blue, mid_eff.blue,
                             win_c1[2].blue, win_c2[2].blue, b_cur.blue);
    end
  end

  // Output queue; input is open only while a result in flight is sure of a slot.
  assign push      = b_valid && b_emit;
  assign pop       = out_valid && out_ready;
  assign out_valid = (q_count != '0);
  assign in_ready  = ({1'b0, q_count} + {2'b00, push}) < 3'(FIFO_DEPTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      q_count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_BITS'(FIFO_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_BITS'(FIFO_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        q_count <= q_count + 1'b1;
      end else if (pop && !push) begin
        q_count <= q_count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= res;
    end
  end

  assign red_out   = q[rd_ptr].pix.red;
  assign green_out = q[rd_ptr].pix.green;
  assign blue_out  = q[rd_ptr].pix.blue;
  assign frame_end = q[rd_ptr].frame_end;

  // A result never arrives at a full queue.
  a_queue_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push && !pop |-> q_count < QCNT_BITS'(FIFO_DEPTH))
    else $error("output queue overflow");

  // Input back-pressure only when results are actually waiting.
  a_stall_has_backlog: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> q_count >= QCNT_BITS'(2))
    else $error("input stalled without a result backlog");

  // The output column stays inside the frame.
  a_out_column_in_frame: assert property (@(posedge clk) disable iff (rst)
    {1'b0, out_column} < frame_width)
    else $error("output column beyond frame width");

  // The frame-end result returns the output position, input column and pending count to the frame start.
  a_frame_end_restarts: assert property (@(posedge clk) disable iff (rst)
    take && emit && last |=> out_row == '0 && out_column == '0 &&
      in_column == '0 && pending_count == '0)
    else $error("frame end did not restart the frame");

endmodule

### test/tb.sv
// Self-checking testbench for the streaming 3x3 neighbour blur.
`timescale 1ns / 100ps

module tb;
  import nab_pkg::*;

  localparam int LINE_DEPTH     = 1024;
  localparam int MAX_ROWS       = 4096;
  localparam int SETTLE_CYCLES  = 8;
  localparam int RANDOM_ITEMS   = 80;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 2000;

  logic                      clk = 1'b0;
  logic                      rst;
  logic                      write_enable;
  logic [REG_INDEX_BITS-1:0] write_index;
  logic [CFG_DATA_BITS-1:0]  write_data;
  logic                      in_valid;
  logic                      in_ready;
  logic                      operation;
  logic [CHAN_BITS-1:0]      red_in;
  logic [CHAN_BITS-1:0]      green_in;
  logic [CHAN_BITS-1:0]      blue_in;
  logic                      out_valid;
  logic                      out_ready;
  logic [CHAN_BITS-1:0]      red_out;
  logic [CHAN_BITS-1:0]      green_out;
  logic [CHAN_BITS-1:0]      blue_out;
  logic                      frame_end;

  neighbour_average_blur_3x3 #(
    .MAX_WIDTH (LINE_DEPTH),
    .MAX_HEIGHT(MAX_ROWS)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .write_enable(write_enable),
    .write_index (write_index),
    .write_data  (write_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .operation   (operation),
    .red_in      (red_in),
    .green_in    (green_in),
    .blue_in     (blue_in),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .red_out     (red_out),
    .green_out   (green_out),
    .blue_out    (blue_out),
    .frame_end   (frame_end)
  );

  // Shared control between the stimulus, the consumer and the checker.
  result_t     blurred_pixels[$];
  int          failures;
  int          receiver_hold;
  int          hold_requests;
  bit          sender_gaps;
  bit          receiver_stalls;
  int          idle_cycles;

  // Predictor state: geometry, line stores, window and raster counters.
  int unsigned width_px;
  int unsigned height_rows;
  pixel_t      line_above [LINE_DEPTH];
  pixel_t      line_mid [LINE_DEPTH];
  pixel_t      window [3][3];
  int unsigned col_in;
  int unsigned row_in;
  int unsigned col_out;
  int unsigned row_out;
  int unsigned primed;

  always #1 clk = ~clk;

  // Put all raster counters back to the start of a frame.
  function automatic void restart_raster();
    col_in  = 0;
    row_in  = 0;
    col_out = 0;
    row_out = 0;
    primed  = 0;
  endfunction

  // Sum of the eight neighbours of one channel, each divided by 8 first.
  function automatic logic [CHAN_BITS-1:0] neighbour_eighths(input int shift);
    logic [CHAN_BITS-1:0] acc;
    logic [PIXEL_BITS-1:0] p;
    acc = '0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if (r != 1 || c != 1) begin
          p = window[r][c];
          acc = acc + CHAN_BITS'(((p >> shift) & 24'hFF) >> 3);
        end
      end
    end
    return acc;
  endfunction

  // Advance the predictor by one accepted transaction; returns 1 when a
  // blurred pixel leaves for it.
  function automatic bit blurred_pixel_for(input logic op, input pixel_t pix,
                                           output result_t res);
    pixel_t      cur;
    pixel_t      up;
    pixel_t      mid;
    int unsigned col;
    bit          draining;
    bit          last;
    res = '0;
    draining = (row_in >= height_rows);
    if (op == OP_FLUSH && !draining) return 1'b0;
    cur = draining ? pixel_t'('0) : pix;
    col = (col_in >= LINE_DEPTH) ? 0 : col_in;
    up  = line_above[col];
    mid = line_mid[col];
    line_above[col] = mid;
    line_mid[col]   = cur;
    for (int r = 0; r < 3; r++) begin
      window[r][0] = window[r][1];
      window[r][1] = window[r][2];
    end
    window[0][2] = up;
    window[1][2] = mid;
    window[2][2] = cur;
    col_in++;
    if (col_in >= width_px) begin
      col_in = 0;
      row_in++;
    end
    if (primed < width_px + 1) begin
      primed++;
      return 1'b0;
    end
    // Border pixels keep the centre value; interior ones take the neighbour sum.
    if (col_out == 0 || row_out == 0 || col_out == width_px - 1 ||
        row_out == height_rows - 1) begin
      res.pix = window[1][1];
    end else begin
      res.pix.red   = neighbour_eighths(16);
      res.pix.green = neighbour_eighths(8);
      res.pix.blue  = neighbour_eighths(0);
    end
    last = (row_out >= height_rows - 1 && col_out >= width_px - 1);
    res.frame_end = last;
    if (last) begin
      restart_raster();
    end else begin
      col_out++;
      if (col_out >= width_px) begin
        col_out = 0;
        row_out++;
      end
    end
    return 1'b1;
  endfunction

  function automatic pixel_t random_pixel();
    logic [PIXEL_BITS-1:0] bits;
    bits = PIXEL_BITS'($urandom);
    return bits;
  endfunction

  // Random frame width, with stray bits above the register field.
  function automatic logic [CFG_DATA_BITS-1:0] random_width();
    return CFG_DATA_BITS'($urandom_range(0, 12) | ($urandom_range(0, 3) << WIDTH_REG_BITS));
  endfunction

  function automatic logic [CFG_DATA_BITS-1:0] random_height();
    return CFG_DATA_BITS'($urandom_range(0, 9));
  endfunction

  // Offer one transaction, hold it until accepted, and queue its prediction.
  task automatic send_item(input logic op, input pixel_t pix);
    result_t res;
    if (sender_gaps && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_valid  <= 1'b1;
    operation <= op;
    red_in    <= pix.red;
    green_in  <= pix.green;
    blue_in   <= pix.blue;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (blurred_pixel_for(op, pix, res)) blurred_pixels.push_back(res);
    @(negedge clk);
  endtask

  // Stop offering and wait until every predicted pixel has been checked.
  task automatic wait_drained(input int settle);
    in_valid <= 1'b0;
    while (blurred_pixels.size() != 0) @(negedge clk);
    repeat (settle + 1) @(negedge clk);
  endtask

  task automatic write_register(input logic [REG_INDEX_BITS-1:0] idx,
                                input logic [CFG_DATA_BITS-1:0] data);
    int unsigned v;
    write_enable <= 1'b1;
    write_index  <= idx;
    write_data   <= data;
    @(posedge clk);
    // Mirror the clamping of the register into the predictor.
    if (idx == REG_FRAME_WIDTH) begin
      v = 32'(data[WIDTH_REG_BITS-1:0]);
      width_px = (v < 1) ? 1 : (v > LINE_DEPTH) ? LINE_DEPTH : v;
    end else begin
      v = 32'(data[HEIGHT_REG_BITS-1:0]);
      height_rows = (v < 1) ? 1 : (v > MAX_ROWS) ? MAX_ROWS : v;
    end
    restart_raster();
    @(negedge clk);
    write_enable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_geometry(input logic [CFG_DATA_BITS-1:0] wd,
                              input logic [CFG_DATA_BITS-1:0] hd);
    wait_drained(SETTLE_CYCLES);
    write_register(REG_FRAME_WIDTH, wd);
    write_register(REG_FRAME_HEIGHT, hd);
  endtask

  // Send pixels of the current frame, with stray flushes mixed in if noisy.
  task automatic send_pixels(input int unsigned count, input bit noisy);
    for (int unsigned i = 0; i < count; i++) begin
      if (noisy && $urandom_range(0, 19) == 0) send_item(OP_FLUSH, random_pixel());
      send_item(OP_PIXEL, random_pixel());
    end
  endtask

  // Drain the frame with a mix of flushes and pixels that count as flushes.
  task automatic send_drain(input bit noisy);
    for (int unsigned i = 0; i <= width_px; i++) begin
      send_item($urandom_range(0, 1) ? OP_FLUSH : OP_PIXEL, random_pixel());
    end
    if (noisy && $urandom_range(0, 2) == 0) send_item(OP_FLUSH, random_pixel());
  endtask

  // The reset geometry of 640 columns sets the lag of the first results.
  task automatic test_reset_geometry();
    send_pixels(645, 1'b0);
  endtask

  // Zero width and height clamp to a single pixel frame.
  task automatic test_single_pixel_frame();
    set_geometry(0, 0);
    send_item(OP_FLUSH, 24'h123456);
    send_item(OP_PIXEL, 24'hFF00FF);
    send_item(OP_PIXEL, 24'h00FF00);
    send_item(OP_FLUSH, 24'hA5A5A5);
    send_item(OP_FLUSH, 24'h5A5A5A);
  endtask

  // One interior pixel surrounded by extreme channel values.
  task automatic test_interior_3x3();
    pixel_t pattern [9];
    pattern = '{24'hFFFFFF, 24'h000000, 24'hF80780, 24'hFF007F, 24'h123456,
                24'h00FF00, 24'h07F801, 24'hFFFFFF, 24'h808080};
    set_geometry(3, 3);
    for (int k = 0; k < 9; k++) begin
      if (k == 4) send_item(OP_FLUSH, 24'hFFFFFF);
      send_item(OP_PIXEL, pattern[k]);
    end
    for (int i = 0; i < 4; i++) send_item(i[0] ? OP_FLUSH : OP_PIXEL, 24'hFFFFFF);
    send_item(OP_FLUSH, 24'h000000);
  endtask

  // A register write in the middle of a frame starts a fresh frame.
  task automatic test_restart_on_write();
    set_geometry(4, 4);
    send_pixels(9, 1'b0);
    wait_drained(SETTLE_CYCLES);
    write_register(REG_FRAME_HEIGHT, 4);
    send_pixels(16, 1'b0);
    send_drain(1'b0);
  endtask

  // The consumer holds off long enough for the input to stall, then the
  // producer pauses in mid-frame until every result has arrived.
  task automatic test_backpressure();
    set_geometry(8, 6);
    receiver_hold = HOLD_CYCLES;
    hold_requests++;
    send_pixels(24, 1'b0);
    wait_drained(0);
    send_pixels(24, 1'b0);
    send_drain(1'b0);
  endtask

  // Random small frames, some broken off by a register write.
  task automatic test_random_frames();
    int unsigned sent;
    int unsigned cut;
    sent = 0;
    set_geometry(random_width(), random_height());
    while (sent < RANDOM_ITEMS) begin
      sender_gaps     = ($urandom_range(0, 2) != 0);
      receiver_stalls = ($urandom_range(0, 2) != 0);
      if ($urandom_range(0, 3) == 0) begin
        set_geometry(random_width(), random_height());
      end
      if ($urandom_range(0, 7) == 0) begin
        cut = $urandom_range(1, width_px * height_rows);
        send_pixels(cut, 1'b1);
        sent += cut;
        set_geometry(random_width(), random_height());
      end else begin
        sent += width_px * height_rows + width_px + 1;
        send_pixels(width_px * height_rows, 1'b1);
        send_drain(1'b1);
      end
    end
  endtask

  // Oversized register values clamp to the largest width and height, so no
  // result leaves early; then a clean frame runs with no idling.
  task automatic test_largest_frames();
    sender_gaps     = 1'b0;
    receiver_stalls = 1'b0;
    set_geometry(13'h07FF, 13'h1FFF);
    send_pixels(24, 1'b0);
    set_geometry(6, 4);
    send_pixels(width_px * height_rows, 1'b0);
    send_drain(1'b0);
  endtask

  // Consumer: random stalls, and long hold-offs on request.
  initial begin : consume_results
    int hold;
    int holds_served;
    holds_served = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_requests != holds_served) begin
        holds_served++;
        hold = receiver_hold;
        out_ready <= 1'b0;
        repeat (hold - 1) @(negedge clk);
      end else if (receiver_stalls && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(0, 4)) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Compare every accepted result transaction with the oldest prediction.
  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && out_valid && out_ready) begin
      if (blurred_pixels.size() == 0) begin
        $error("unexpected result: red_out %0d green_out %0d blue_out %0d frame_end %0d",
               red_out, green_out, blue_out, frame_end);
        failures++;
      end else begin
        want = blurred_pixels.pop_front();
        if (red_out !== want.pix.red) begin
          $error("red_out: expected %0d, got %0d", want.pix.red, red_out);
          failures++;
        end
        if (green_out !== want.pix.green) begin
          $error("green_out: expected %0d, got %0d", want.pix.green, green_out);
          failures++;
        end
        if (blue_out !== want.pix.blue) begin
          $error("blue_out: expected %0d, got %0d", want.pix.blue, blue_out);
          failures++;
        end
        if (frame_end !== want.frame_end) begin
          $error("frame_end: expected %0d, got %0d", want.frame_end, frame_end);
          failures++;
        end
      end
    end
  end

  // Watchdog on cycles in which no transaction or register write happens.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || write_enable) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst             = 1'b1;
    write_enable    = 1'b0;
    write_index     = REG_FRAME_WIDTH;
    write_data      = '0;
    in_valid        = 1'b0;
    operation       = OP_PIXEL;
    red_in          = '0;
    green_in        = '0;
    blue_in         = '0;
    receiver_hold   = 0;
    hold_requests   = 0;
    sender_gaps     = 1'b1;
    receiver_stalls = 1'b1;
    width_px        = WIDTH_RESET;
    height_rows     = HEIGHT_RESET;
    for (int i = 0; i < LINE_DEPTH; i++) begin
      line_above[i] = '0;
      line_mid[i]   = '0;
    end
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) window[r][c] = '0;
    end
    restart_raster();
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    test_reset_geometry();
    test_single_pixel_frame();
    test_interior_3x3();
    test_restart_on_write();
    test_backpressure();
    test_random_frames();
    test_largest_frames();
    wait_drained(SETTLE_CYCLES);

    if (failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### neighbour_average_blur_3x3.f
sv/nab_pkg.sv
sv/nab_ram.sv
sv/neighbour_average_blur_3x3.sv
test/tb.sv
